// File: sv/edn_pkg.sv
package edn_pkg;

  localparam int DEF_NODE_CAPACITY = 1024;
  localparam int COORD_W = 32;
  localparam int KEY_W = 64;
  localparam int OUT_NODE_W = 10;

  localparam logic [0:0] REG_SNAP_ENABLE = 1'd0;
  localparam logic [0:0] REG_INVERSE_STEP = 1'd1;

  localparam logic RST_SNAP_ENABLE = 1'b1;
  localparam logic [31:0] RST_INVERSE_STEP = 32'd1677721600;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SNAP,
    S_RD,
    S_CMP,
    S_DONE
  } state_t;

endpackage

// File: sv/edn_snap.sv
module edn_snap (
  input  logic                        clk,
  input  logic [edn_pkg::COORD_W-1:0] coord,
  input  logic [31:0]                 inv_step,
  output logic [edn_pkg::COORD_W-1:0] grid
);
  import edn_pkg::*;

  logic [COORD_W-1:0] mag;
  logic [63:0]        prod_r;
  logic               neg_r;
  logic [63:0]        sp;

  // 0x80000000 negates to itself, which is the right magnitude 2^31
  assign mag = coord[COORD_W-1] ? (~coord + 32'd1) : coord;

  always_ff @(posedge clk) begin
    prod_r <= 64'(mag) * 64'(inv_step);
    neg_r  <= coord[COORD_W-1];
  end

  // floor(p + 0.5) on Q24.40; sign fill follows the input sign
  assign sp   = neg_r ? (~prod_r + 64'd1) : prod_r;
  assign grid = {{8{neg_r}}, sp[63:40]} + 32'(sp[39]);

endmodule

// File: sv/edn_ram.sv
module edn_ram #(
  parameter int ADDR_W = 10,
  parameter int DATA_W = 75
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// File: sv/endpoint_node_dedup_table.sv
// Endpoint node dedup table.
// Input channel (in_valid/in_ready) takes one line part: start and end point,
// Q16.16 coordinates. Result channel (out_valid/out_ready) returns one
// transaction per input: node numbers of both points, their is_new flags and
// table_full. Nodes are numbered in order of first appearance of a key.
// Keys (grid index pairs when snapping, raw coordinates otherwise) live in
// a hash table in one single-port-read RAM with linear probing.
// Snapping runs through one shared multiplier in state S_SNAP; then each
// probe, first for the start key and then for the end key, passes S_RD and
// S_CMP, and S_DONE loads the output register. A lookup of a new key on a
// full table walks on to an empty slot, or every slot if all are taken.
// One item is in work at a time; the next is taken as soon as the current
// result is in the output register, even while the receiver stalls.
// A stalled receiver holds the result; a finished item waits for it.
// After reset the table RAM is swept to empty, one entry a cycle, over all
// 2**clog2(NODE_CAPACITY) entries; in_ready stays low meanwhile.
// Configuration writes take effect at once and are expected while idle.
module endpoint_node_dedup_table #(
  parameter int NODE_CAPACITY = edn_pkg::DEF_NODE_CAPACITY
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [0:0]                     cfg_index,
  input  logic [31:0]                    cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [edn_pkg::COORD_W-1:0]    in_start_x,
  input  logic [edn_pkg::COORD_W-1:0]    in_start_y,
  input  logic [edn_pkg::COORD_W-1:0]    in_end_x,
  input  logic [edn_pkg::COORD_W-1:0]    in_end_y,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [edn_pkg::OUT_NODE_W-1:0] out_start_node,
  output logic [edn_pkg::OUT_NODE_W-1:0] out_end_node,
  output logic                           out_start_is_new,
  output logic                           out_end_is_new,
  output logic                           out_table_full
);
  import edn_pkg::*;

  localparam int IDX_W = $clog2(NODE_CAPACITY);
  localparam int DEPTH = 2**IDX_W;
  localparam int NODE_W = IDX_W;
  localparam int CNT_W = $clog2(NODE_CAPACITY + 1);
  localparam int ENT_W = 1 + KEY_W + NODE_W;

  function automatic logic [IDX_W-1:0] hash_key(input logic [KEY_W-1:0] k);
    logic [IDX_W-1:0] h;
    h = '0;
    for (int i = 0; i < KEY_W; i++) begin
      h[i % IDX_W] = h[i % IDX_W] ^ k[i];
    end
    return h;
  endfunction

  state_t state_r, state_nxt;

  logic               snap_en_r;
  logic [31:0]        inv_step_r;

  logic [COORD_W-1:0] crd_r [4];
  logic [COORD_W-1:0] key_r [4];
  logic [2:0]         cnt_r;
  logic [IDX_W-1:0]   probe_r, probe_nxt;
  logic [IDX_W:0]     tries_r, tries_nxt;
  logic               sel_end_r, sel_end_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [IDX_W:0]     clr_r;

  logic [NODE_W-1:0]  s_node_r, s_node_nxt, e_node_r, e_node_nxt;
  logic               s_new_r, s_new_nxt, e_new_r, e_new_nxt;
  logic               full_r, full_nxt;

  logic               out_valid_r;
  logic [OUT_NODE_W-1:0] out_s_node_r, out_e_node_r;
  logic               out_s_new_r, out_e_new_r, out_full_r;

  logic [COORD_W-1:0] grid;
  logic [1:0]         key_idx;

  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [ENT_W-1:0]   wr_data;
  logic [ENT_W-1:0]   rd_data;

  logic [KEY_W-1:0]   cur_key;
  logic               ent_valid;
  logic [KEY_W-1:0]   ent_key;
  logic [NODE_W-1:0]  ent_node;
  logic               hit;
  logic               lookup_done;
  logic [NODE_W-1:0]  found_node;
  logic               found_new;
  logic               found_full;
  logic               in_acc;
  logic               out_load;

  edn_snap u_snap (
    .clk      (clk),
    .coord    (crd_r[cnt_r[1:0]]),
    .inv_step (inv_step_r),
    .grid     (grid)
  );

  edn_ram #(.ADDR_W(IDX_W), .DATA_W(ENT_W)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (probe_r),
    .rd_data (rd_data)
  );

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign key_idx  = 2'(cnt_r - 3'd1);

  assign cur_key   = sel_end_r ? {key_r[2], key_r[3]} : {key_r[0], key_r[1]};
  assign ent_valid = rd_data[ENT_W-1];
  assign ent_key   = rd_data[ENT_W-2 -: KEY_W];
  assign ent_node  = rd_data[NODE_W-1:0];
  assign hit       = ent_valid && (ent_key == cur_key);

  // probe result
  always_comb begin
    lookup_done = 1'b0;
    found_node  = '0;
    found_new   = 1'b0;
    found_full  = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = probe_r;
    wr_data     = {1'b1, cur_key, count_r[NODE_W-1:0]};
    probe_nxt   = probe_r;
    tries_nxt   = tries_r;
    count_nxt   = count_r;
    case (state_r)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r[IDX_W-1:0];
        wr_data = '0;
      end
      S_SNAP: begin
        probe_nxt = hash_key({key_r[0], key_r[1]});
        tries_nxt = '0;
      end
      S_CMP: begin
        if (hit) begin
          lookup_done = 1'b1;
          found_node  = ent_node;
        end else if (!ent_valid) begin
          lookup_done = 1'b1;
          if (count_r < CNT_W'(NODE_CAPACITY)) begin
            wr_en      = 1'b1;
            found_node = count_r[NODE_W-1:0];
            found_new  = 1'b1;
            count_nxt  = count_r + CNT_W'(1);
          end else begin
            found_full = 1'b1;
          end
        end else if (tries_r + (IDX_W+1)'(1) == (IDX_W+1)'(DEPTH)) begin
          // every slot taken and none matches
          lookup_done = 1'b1;
          found_full  = 1'b1;
        end else begin
          probe_nxt = probe_r + IDX_W'(1);
          tries_nxt = tries_r + (IDX_W+1)'(1);
        end
        if (lookup_done && !sel_end_r) begin
          probe_nxt = hash_key({key_r[2], key_r[3]});
          tries_nxt = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    s_node_nxt  = s_node_r;
    e_node_nxt  = e_node_r;
    s_new_nxt   = s_new_r;
    e_new_nxt   = e_new_r;
    full_nxt    = full_r;
    sel_end_nxt = sel_end_r;
    if (in_acc) begin
      full_nxt    = 1'b0;
      sel_end_nxt = 1'b0;
    end else if (state_r == S_CMP && lookup_done) begin
      full_nxt = full_r | found_full;
      if (sel_end_r) begin
        e_node_nxt = found_node;
        e_new_nxt  = found_new;
      end else begin
        s_node_nxt  = found_node;
        s_new_nxt   = found_new;
        sel_end_nxt = 1'b1;
      end
    end
  end

  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (clr_r == (IDX_W+1)'(DEPTH - 1)) state_nxt = S_IDLE;
      S_IDLE:  if (in_valid) state_nxt = S_SNAP;
      S_SNAP:  if (cnt_r == 3'd4) state_nxt = S_RD;
      S_RD:    state_nxt = S_CMP;
      S_CMP: begin
        if (!lookup_done) state_nxt = S_RD;
        else if (sel_end_r) state_nxt = S_DONE;
        else state_nxt = S_RD;
      end
      S_DONE:  if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      snap_en_r   <= RST_SNAP_ENABLE;
      inv_step_r  <= RST_INVERSE_STEP;
      cnt_r       <= '0;
      clr_r       <= '0;
      count_r     <= '0;
      sel_end_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      sel_end_r <= sel_end_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_SNAP_ENABLE:  snap_en_r  <= cfg_data[0];
          REG_INVERSE_STEP: inv_step_r <= cfg_data;
          default: begin
          end
        endcase
      end
      if (state_r == S_CLEAR) clr_r <= clr_r + (IDX_W+1)'(1);
      if (in_acc) cnt_r <= '0;
      else if (state_r == S_SNAP) cnt_r <= cnt_r + 3'd1;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    probe_r  <= probe_nxt;
    tries_r  <= tries_nxt;
    s_node_r <= s_node_nxt;
    e_node_r <= e_node_nxt;
    s_new_r  <= s_new_nxt;
    e_new_r  <= e_new_nxt;
    full_r   <= full_nxt;
    if (in_acc) begin
      crd_r[0] <= in_start_x;
      crd_r[1] <= in_start_y;
      crd_r[2] <= in_end_x;
      crd_r[3] <= in_end_y;
    end
    if (state_r == S_SNAP && cnt_r != 3'd0) begin
      key_r[key_idx] <= snap_en_r ? grid : crd_r[key_idx];
    end
    if (out_load) begin
      out_s_node_r <= OUT_NODE_W'(s_node_r);
      out_e_node_r <= OUT_NODE_W'(e_node_r);
      out_s_new_r  <= s_new_r;
      out_e_new_r  <= e_new_r;
      out_full_r   <= full_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_start_node   = out_s_node_r;
  assign out_end_node     = out_e_node_r;
  assign out_start_is_new = out_s_new_r;
  assign out_end_is_new   = out_e_new_r;
  assign out_table_full   = out_full_r;

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(NODE_CAPACITY))
    else $error("node count above capacity");

  a_acc_snap: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == S_SNAP && cnt_r == 3'd0)
    else $error("accepted item did not enter snapping");

  a_full_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && full_r |-> count_r == CNT_W'(NODE_CAPACITY))
    else $error("table_full with free entries");

  a_new_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && s_new_r && e_new_r |-> s_node_r != e_node_r)
    else $error("two inserts got one node");

endmodule
